// File: rtl/asw_pkg.sv
`default_nettype none
package asw_pkg;

  localparam int DEPTH     = 64;
  localparam int LINK_BITS = 16;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam int OP_W      = 2;
  localparam int CONN_W    = 16;
  localparam int TIME_W    = 32;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 7;

  localparam int IN_W      = 56;
  localparam int OUT_W     = 64;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'h0100_0000;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ELAPSE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep;
    logic load_out;
  } asw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            sweep_done;
  } asw_stat_t;

  // Ring pointer advance; b never exceeds DEPTH, so one subtract suffices.
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [CNT_W-1:0]  b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/asw_ctrl.sv
`default_nettype none
module asw_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  wire asw_pkg::asw_stat_t stat,
  output asw_pkg::asw_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SWEEP  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.capture  = in_tvalid && (state_r == S_IDLE);
    cmd.exec     = (state_r == S_EXEC);
    cmd.sweep    = (state_r == S_SWEEP);
    cmd.load_out = (state_r == S_FINISH) && (!out_valid_r || out_tready);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.op == asw_pkg::OP_ELAPSE) state_nxt = S_SWEEP;
        else state_nxt = S_FINISH;
      end
      S_SWEEP: begin
        if (stat.sweep_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/asw_dp.sv
`default_nettype none
module asw_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire asw_pkg::asw_cmd_t           cmd,
  output asw_pkg::asw_stat_t               stat,
  input  wire [asw_pkg::OP_W-1:0]          in_tuser,
  input  wire [asw_pkg::IN_W-1:0]          in_tdata,
  input  wire                              cfg_wr_en,
  input  wire [asw_pkg::TIME_W-1:0]        cfg_wr_data,
  output logic [asw_pkg::OUT_W-1:0]        out_tdata
);

  localparam int AW = asw_pkg::ADDR_W;
  localparam int CW = asw_pkg::CNT_W;
  localparam int TW = asw_pkg::TIME_W;
  localparam int LW = asw_pkg::LINK_BITS;

  logic [TW-1:0]              window_r;
  logic [asw_pkg::OP_W-1:0]   op_r;
  logic [asw_pkg::CONN_W-1:0] conn_r;
  logic [TW-1:0]              elapsed_r;
  logic [asw_pkg::POS_W-1:0]  pos_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          found_r;
  logic          ovf_r;

  // Sweep pipeline: read one entry per cycle, write it back in the following cycle.
  logic [CW-1:0] rd_k_r;
  logic [AW-1:0] rd_ptr_r;
  logic          sv_r;
  logic [AW-1:0] wr_addr_r;
  logic [CW-1:0] npop_r;

  logic [TW-1:0] age_mem_r [asw_pkg::DEPTH];
  logic [LW-1:0] link_mem_r [asw_pkg::DEPTH];
  logic [TW-1:0] age_q_r;
  logic [LW-1:0] link_q_r;

  logic [asw_pkg::COUNT_W-1:0]  out_count_r;
  logic                         out_found_r;
  logic [TW-1:0]                out_age_r;
  logic [asw_pkg::CONN_W-1:0]   out_link_r;
  logic                         out_ovf_r;

  logic          full;
  logic          rd_in_range;
  logic [AW-1:0] rd_slot;
  logic          exec_add;
  logic          exec_rd;
  logic          sw_issue;
  logic          sw_wb;
  logic          sw_done;
  logic [TW:0]   sum;
  logic [TW-1:0] age_new;
  logic          age_rd_en;
  logic [AW-1:0] age_rd_addr;
  logic          age_wr_en;
  logic [AW-1:0] age_wr_addr;
  logic [TW-1:0] age_wr_data;

  always_comb begin
    full        = (count_r == CW'(asw_pkg::DEPTH));
    rd_in_range = (32'(pos_r) < 32'(count_r));
    rd_slot     = asw_pkg::wrap_add(head_r, CW'(pos_r));
    exec_add    = cmd.exec && (op_r == asw_pkg::OP_ADD) && !full;
    exec_rd     = cmd.exec && (op_r == asw_pkg::OP_READ) && rd_in_range;
    sw_issue    = cmd.sweep && (rd_k_r != count_r);
    sw_wb       = cmd.sweep && sv_r;
    sw_done     = (rd_k_r == count_r) && !sv_r;
    sum         = {1'b0, age_q_r} + {1'b0, elapsed_r};
    age_new     = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

    age_rd_en   = exec_rd || sw_issue;
    age_rd_addr = sw_issue ? rd_ptr_r : rd_slot;
    age_wr_en   = exec_add || sw_wb;
    age_wr_addr = exec_add ? tail_r : wr_addr_r;
    age_wr_data = exec_add ? '0 : age_new;
  end

  always_comb begin
    stat.op         = op_r;
    stat.sweep_done = sw_done;
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (exec_add) begin
      tail_nxt  = asw_pkg::wrap_add(tail_r, CW'(1));
      count_nxt = count_r + CW'(1);
    end else if (cmd.sweep && sw_done) begin
      // Ages never increase toward the tail, so the entries over the window
      // form a prefix at the head and can be dropped in one step.
      head_nxt  = asw_pkg::wrap_add(head_r, npop_r);
      count_nxt = count_r - npop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= asw_pkg::WINDOW_RESET;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      sv_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) window_r <= cfg_wr_data;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (cmd.exec) sv_r <= 1'b0;
      else if (cmd.sweep) sv_r <= sw_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_tuser;
      conn_r    <= in_tdata[15:0];
      elapsed_r <= in_tdata[47:16];
      pos_r     <= in_tdata[53:48];
    end
    if (cmd.exec) begin
      found_r  <= exec_rd;
      ovf_r    <= (op_r == asw_pkg::OP_ADD) && full;
      rd_k_r   <= '0;
      rd_ptr_r <= head_r;
      npop_r   <= '0;
    end
    if (sw_issue) begin
      rd_k_r    <= rd_k_r + CW'(1);
      rd_ptr_r  <= asw_pkg::wrap_add(rd_ptr_r, CW'(1));
      wr_addr_r <= rd_ptr_r;
    end
    if (sw_wb && (age_new > window_r)) npop_r <= npop_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (age_wr_en) age_mem_r[age_wr_addr] <= age_wr_data;
    if (age_rd_en) age_q_r <= age_mem_r[age_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (exec_add) link_mem_r[tail_r] <= conn_r[LW-1:0];
    if (exec_rd) link_q_r <= link_mem_r[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_count_r <= asw_pkg::COUNT_W'(count_r);
      out_found_r <= found_r;
      out_age_r   <= found_r ? age_q_r : '0;
      out_link_r  <= found_r ? asw_pkg::CONN_W'(link_q_r) : '0;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_tdata = {7'b0, out_ovf_r, out_link_r, out_age_r, out_found_r, out_count_r};

endmodule
`default_nettype wire

// File: rtl/aging_spike_window_fifo.sv
`default_nettype none
// Bounded FIFO of recent input spikes for one neuron, holding up to 64 entries
// of an age (unsigned 8.24 fixed point seconds) and a connection id. Op 0 appends
// an entry of age zero (refused with overflow set when full), op 1 adds an elapsed
// time to every age with saturation and then drops head entries whose age is above
// the window register, op 2 reads the entry at a position counted from the oldest.
// Every transfer in produces exactly one transfer out carrying the entry count.
// Items are processed one at a time: add, read and the unused op pass from capture
// through an execute state to a finish state that loads the result once the output
// register is free, and an elapse passes through a sweep state in between, since
// the age memory has one read and one write port and each held age is read, updated
// and written back once, followed by a step that drops the expired head entries.
// The input is ready again in the cycle after the result is loaded. A finished
// result sits in an output register, so the next input transfer is taken while it
// waits. The window register can be written at any time the block holds no
// unfinished item; it resets to 1.0 s.
module aging_spike_window_fifo (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0: connection_id[15:0], elapsed[47:16], position[53:48],
  // zero fill up to bit 55.
  input  wire [asw_pkg::IN_W-1:0]       in_tdata,
  // Operation: 0 add spike, 1 elapse time, 2 read entry.
  input  wire [asw_pkg::OP_W-1:0]       in_tuser,
  output logic                          out_tvalid,
  input  wire                           out_tready,
  // Fields from bit 0: count[6:0], found[7], age[39:8], link[55:40],
  // overflow[56], zero fill up to bit 63.
  output logic [asw_pkg::OUT_W-1:0]     out_tdata,
  input  wire                           cfg_wr_en,
  input  wire [asw_pkg::TIME_W-1:0]     cfg_wr_data
);

  asw_pkg::asw_cmd_t  cmd;
  asw_pkg::asw_stat_t stat;

  // The controller sequences each item and owns both handshakes.
  asw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds the ring storage, pointers, window and result register.
  asw_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire
